// ===== rtl/core/emp_pkg.sv =====
// ----------------------------------------------------------------------------
// Electrode to magnetic position mapper package
// Shared constants, operation codes and beat types.
// ----------------------------------------------------------------------------
package emp_pkg;

    localparam int EMP_NUM_ELECTRODES = 64;
    localparam int EMP_FRAC_BITS      = 16;

    localparam logic [2:0] OP_INIT      = 3'd0;
    localparam logic [2:0] OP_REF       = 3'd1;
    localparam logic [2:0] OP_CONVERT   = 3'd2;
    localparam logic [2:0] OP_CLEAR_ONE = 3'd3;
    localparam logic [2:0] OP_CLEAR_ALL = 3'd4;

    localparam logic REG_REF_ELECTRODE = 1'b0;
    localparam logic REG_AUTO_UPDATE   = 1'b1;

    typedef struct packed {
        logic [2:0]         operation;
        logic [5:0]         electrode;
        logic signed [31:0] elec_x;
        logic signed [31:0] elec_y;
        logic signed [31:0] elec_z;
        logic signed [31:0] mag_in_x;
        logic signed [31:0] mag_in_y;
        logic signed [31:0] mag_in_z;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] mag_out_x;
        logic signed [31:0] mag_out_y;
        logic signed [31:0] mag_out_z;
        logic               scale_valid;
        logic               electrode_inited;
    } t_out_item;

endpackage

// ===== rtl/core/emp_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module emp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/core/electrode_to_magnetic_position_mapper.sv =====
// One beat is processed at a time. A reference beat whose scale is valid runs two 32-step
// square roots and the (32 + FRAC_BITS)-step divider. The next beat is taken the cycle
// after a result is registered, even while that result waits at the output.
// After reset a clearing pass zeroes the RAMs before the first beat.
// ----------------------------------------------------------------------------
// Electrode to magnetic position mapper
// Per-electrode position RAM, shared axis scale and a sequenced datapath.
// ----------------------------------------------------------------------------
module electrode_to_magnetic_position_mapper #(
    parameter int NUM_ELECTRODES = emp_pkg::EMP_NUM_ELECTRODES,
    parameter int FRAC_BITS      = emp_pkg::EMP_FRAC_BITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  emp_pkg::t_in_item i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output emp_pkg::t_out_item o_out_data,
    input  logic              i_cfg_we,
    input  logic              i_cfg_index,
    input  logic [5:0]        i_cfg_wdata
);
    import emp_pkg::*;

    localparam int AW   = $clog2(NUM_ELECTRODES);
    localparam int NUMW = 32 + FRAC_BITS;
    localparam int CW   = $clog2(NUMW + 1);
    localparam logic [63:0] THRESH = 64'((64'd1 << (2 * FRAC_BITS)) / 100);

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_RD    = 4'd2;
    localparam logic [3:0] S_LOAD  = 4'd3;
    localparam logic [3:0] S_SQ    = 4'd4;
    localparam logic [3:0] S_CHK   = 4'd5;
    localparam logic [3:0] S_SQRT  = 4'd6;
    localparam logic [3:0] S_DIV   = 4'd7;
    localparam logic [3:0] S_SCALE = 4'd8;
    localparam logic [3:0] S_MUL   = 4'd9;
    localparam logic [3:0] S_WB    = 4'd10;
    localparam logic [3:0] S_DONE  = 4'd11;

    function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
        if (v > 33'sd2147483647) begin
            sat33 = 32'sh7FFFFFFF;
        end else if (v < -33'sd2147483648) begin
            sat33 = 32'sh80000000;
        end else begin
            sat33 = v[31:0];
        end
    endfunction

    function automatic logic signed [31:0] sat65(input logic signed [64:0] v);
        if (v > 65'sd2147483647) begin
            sat65 = 32'sh7FFFFFFF;
        end else if (v < -65'sd2147483648) begin
            sat65 = 32'sh80000000;
        end else begin
            sat65 = v[31:0];
        end
    endfunction

    logic [3:0]          r_state;
    logic                r_clr_pos;
    logic [AW-1:0]       r_cnt;
    t_in_item            r_in;
    logic [5:0]          r_ref_el;
    logic                r_auto;
    logic signed [31:0]  r_de [3];
    logic signed [31:0]  r_dm [3];
    logic signed [31:0]  r_pm [3];
    logic signed [31:0]  r_res [3];
    logic signed [31:0]  r_scale [3];
    logic                r_scale_ok;
    logic                r_inited;
    logic [CW-1:0]       r_step;
    logic signed [63:0]  r_prod;
    logic [63:0]         r_se;
    logic [63:0]         r_sm;
    logic [63:0]         r_rem;
    logic [63:0]         r_root;
    logic [63:0]         r_bit;
    logic                r_sq_ph;
    logic [31:0]         r_ne;
    logic [NUMW-1:0]     r_num;
    logic [NUMW-1:0]     r_q;
    logic [31:0]         r_drem;
    logic                r_out_valid;
    t_out_item           r_out;

    logic                inr;
    logic                ref_in;
    logic                pos_rin;
    logic                pos_we;
    logic [AW-1:0]       pos_waddr;
    logic [191:0]        pos_wdata;
    logic [AW-1:0]       pos_raddr;
    logic [191:0]        pos_rdata;
    logic                flag_we;
    logic [AW-1:0]       flag_waddr;
    logic                flag_wdata;
    logic [0:0]          flag_rdata;
    logic                wb_ok;
    logic                out_free;
    logic signed [32:0]  mul_a;
    logic signed [32:0]  mul_b;
    logic signed [65:0]  mul_p;
    logic [1:0]          ax;
    logic signed [31:0]  sq_v;
    logic [63:0]         sqrt_t;
    logic [63:0]         n_rem;
    logic [63:0]         n_root;
    logic [32:0]         div_r;
    logic [31:0]         k_sat;

    assign inr     = 32'(r_in.electrode) < NUM_ELECTRODES;
    assign ref_in  = 32'(r_ref_el) < NUM_ELECTRODES;
    assign pos_rin = (r_in.operation == OP_REF) ? ref_in : inr;
    assign wb_ok   = inr && r_scale_ok && r_auto;
    assign out_free = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE);

    // RAM addressing: reference beats read the reference electrode's positions,
    // while the flag RAM always follows the beat's electrode field.
    assign pos_raddr  = (r_in.operation == OP_REF) ? AW'(r_ref_el) : AW'(r_in.electrode);
    assign pos_waddr  = (r_state == S_CLEAR) ? r_cnt : AW'(r_in.electrode);
    assign flag_waddr = pos_waddr;

    always_comb begin
        pos_we    = 1'b0;
        pos_wdata = '0;
        flag_we   = 1'b0;
        flag_wdata = 1'b0;
        case (r_state)
            S_CLEAR: begin
                pos_we  = r_clr_pos;
                flag_we = 1'b1;
            end
            S_LOAD: begin
                if (r_in.operation == OP_INIT && inr) begin
                    pos_we     = 1'b1;
                    pos_wdata  = {r_in.elec_x, r_in.elec_y, r_in.elec_z,
                                  r_in.mag_in_x, r_in.mag_in_y, r_in.mag_in_z};
                    flag_we    = 1'b1;
                    flag_wdata = 1'b1;
                end else if (r_in.operation == OP_CLEAR_ONE && inr) begin
                    flag_we = 1'b1;
                end
            end
            S_WB: begin
                pos_we    = wb_ok;
                pos_wdata = {r_in.elec_x, r_in.elec_y, r_in.elec_z,
                             r_res[0], r_res[1], r_res[2]};
            end
            default: begin
            end
        endcase
    end

    emp_ram #(.WIDTH(192), .DEPTH(NUM_ELECTRODES)) u_pos_ram (
        .i_clk   (i_clk),
        .i_we    (pos_we),
        .i_waddr (pos_waddr),
        .i_wdata (pos_wdata),
        .i_raddr (pos_raddr),
        .o_rdata (pos_rdata)
    );

    emp_ram #(.WIDTH(1), .DEPTH(NUM_ELECTRODES)) u_flag_ram (
        .i_clk   (i_clk),
        .i_we    (flag_we),
        .i_waddr (flag_waddr),
        .i_wdata (flag_wdata),
        .i_raddr (AW'(r_in.electrode)),
        .o_rdata (flag_rdata)
    );

    // One shared multiplier: squares of displacement magnitudes for a
    // reference beat, displacement times axis scale for a convert beat.
    always_comb begin
        if (r_state == S_SQ) begin
            ax   = (r_step < CW'(3)) ? r_step[1:0] : 2'(r_step - CW'(3));
            sq_v = (r_step < CW'(3)) ? r_de[ax] : r_dm[ax];
            mul_a = sq_v[31] ? (33'sd0 - {sq_v[31], sq_v}) : {1'b0, sq_v};
            mul_b = mul_a;
        end else begin
            ax    = r_step[1:0];
            sq_v  = r_de[ax];
            mul_a = {sq_v[31], sq_v};
            mul_b = {r_scale[ax][31], r_scale[ax]};
        end
    end
    assign mul_p = mul_a * mul_b;

    assign sqrt_t = r_root + r_bit;
    always_comb begin
        if (r_rem >= sqrt_t) begin
            n_rem  = r_rem - sqrt_t;
            n_root = (r_root >> 1) + r_bit;
        end else begin
            n_rem  = r_rem;
            n_root = r_root >> 1;
        end
    end

    assign div_r = {r_drem, r_num[NUMW-1]};
    assign k_sat = (r_q[NUMW-1:31] != '0) ? 32'h7FFFFFFF : {1'b0, r_q[30:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_pos   <= 1'b1;
            r_cnt       <= '0;
            r_ref_el    <= '0;
            r_auto      <= 1'b1;
            r_scale_ok  <= 1'b0;
            r_scale[0]  <= '0;
            r_scale[1]  <= '0;
            r_scale[2]  <= '0;
            r_out_valid <= 1'b0;
            r_step      <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_REF_ELECTRODE: r_ref_el <= i_cfg_wdata;
                    REG_AUTO_UPDATE:   r_auto   <= i_cfg_wdata[0];
                    default: begin
                    end
                endcase
            end
            if (o_out_valid && i_out_ready && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_CLEAR: begin
                    if (r_cnt == AW'(NUM_ELECTRODES - 1)) begin
                        r_cnt     <= '0;
                        r_clr_pos <= 1'b0;
                        r_state   <= r_clr_pos ? S_IDLE : S_DONE;
                    end else begin
                        r_cnt <= r_cnt + AW'(1);
                    end
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_in    <= i_in_data;
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    r_state <= S_LOAD;
                end
                S_LOAD: begin
                    r_de[0] <= sat33({r_in.elec_x[31], r_in.elec_x}
                               - (pos_rin ? {pos_rdata[191], pos_rdata[191:160]} : 33'sd0));
                    r_de[1] <= sat33({r_in.elec_y[31], r_in.elec_y}
                               - (pos_rin ? {pos_rdata[159], pos_rdata[159:128]} : 33'sd0));
                    r_de[2] <= sat33({r_in.elec_z[31], r_in.elec_z}
                               - (pos_rin ? {pos_rdata[127], pos_rdata[127:96]} : 33'sd0));
                    r_dm[0] <= sat33({r_in.mag_in_x[31], r_in.mag_in_x}
                               - (pos_rin ? {pos_rdata[95], pos_rdata[95:64]} : 33'sd0));
                    r_dm[1] <= sat33({r_in.mag_in_y[31], r_in.mag_in_y}
                               - (pos_rin ? {pos_rdata[63], pos_rdata[63:32]} : 33'sd0));
                    r_dm[2] <= sat33({r_in.mag_in_z[31], r_in.mag_in_z}
                               - (pos_rin ? {pos_rdata[31], pos_rdata[31:0]} : 33'sd0));
                    r_pm[0] <= pos_rin ? pos_rdata[95:64] : '0;
                    r_pm[1] <= pos_rin ? pos_rdata[63:32] : '0;
                    r_pm[2] <= pos_rin ? pos_rdata[31:0]  : '0;
                    r_res[0] <= '0;
                    r_res[1] <= '0;
                    r_res[2] <= '0;
                    r_step   <= '0;
                    r_se     <= '0;
                    r_sm     <= '0;
                    case (r_in.operation)
                        OP_INIT: begin
                            r_inited <= inr;
                            r_state  <= S_DONE;
                        end
                        OP_REF: begin
                            r_inited <= inr && flag_rdata[0];
                            r_state  <= S_SQ;
                        end
                        OP_CONVERT: begin
                            r_inited <= inr && flag_rdata[0];
                            r_state  <= S_MUL;
                        end
                        OP_CLEAR_ONE: begin
                            r_inited <= 1'b0;
                            r_state  <= S_DONE;
                        end
                        OP_CLEAR_ALL: begin
                            r_inited <= 1'b0;
                            r_cnt    <= '0;
                            r_state  <= S_CLEAR;
                        end
                        default: begin
                            r_inited <= inr && flag_rdata[0];
                            r_state  <= S_DONE;
                        end
                    endcase
                end
                S_SQ: begin
                    // Each product is registered in r_prod and summed on the following step.
                    r_prod <= mul_p[63:0];
                    if (r_step != '0) begin
                        if (r_step <= CW'(3)) begin
                            r_se <= r_se + 64'(r_prod);
                        end else begin
                            r_sm <= r_sm + 64'(r_prod);
                        end
                    end
                    r_step <= r_step + CW'(1);
                    if (r_step == CW'(6)) begin
                        r_state <= S_CHK;
                    end
                end
                S_CHK: begin
                    r_scale_ok <= (r_se > THRESH);
                    r_rem      <= r_se;
                    r_root     <= '0;
                    r_bit      <= 64'd1 << 62;
                    r_sq_ph    <= 1'b0;
                    r_state    <= (r_se > THRESH) ? S_SQRT : S_DONE;
                end
                S_SQRT: begin
                    if (r_bit == 64'd1 && !r_sq_ph) begin
                        r_ne    <= (n_root == '0) ? 32'd1 : n_root[31:0];
                        r_sq_ph <= 1'b1;
                        r_rem   <= r_sm;
                        r_root  <= '0;
                        r_bit   <= 64'd1 << 62;
                    end else begin
                        r_rem  <= n_rem;
                        r_root <= n_root;
                        r_bit  <= r_bit >> 2;
                        if (r_bit == 64'd1) begin
                            r_num   <= {n_root[31:0], FRAC_BITS'(0)};
                            r_drem  <= '0;
                            r_q     <= '0;
                            r_step  <= CW'(NUMW);
                            r_state <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    if (div_r >= {1'b0, r_ne}) begin
                        r_drem <= 32'(div_r - {1'b0, r_ne});
                        r_q    <= {r_q[NUMW-2:0], 1'b1};
                    end else begin
                        r_drem <= div_r[31:0];
                        r_q    <= {r_q[NUMW-2:0], 1'b0};
                    end
                    r_num  <= r_num << 1;
                    r_step <= r_step - CW'(1);
                    if (r_step == CW'(1)) begin
                        r_state <= S_SCALE;
                    end
                end
                S_SCALE: begin
                    for (int a = 0; a < 3; a++) begin
                        if ((r_de[a] > 0 && r_dm[a] > 0) || (r_de[a] < 0 && r_dm[a] < 0)) begin
                            r_scale[a] <= k_sat;
                        end else begin
                            r_scale[a] <= 32'd0 - k_sat;
                        end
                    end
                    r_state <= S_DONE;
                end
                S_MUL: begin
                    r_prod <= mul_p[63:0];
                    if (r_step != '0) begin
                        r_res[2'(r_step - CW'(1))] <= sat65(
                            {{33{r_pm[2'(r_step - CW'(1))][31]}}, r_pm[2'(r_step - CW'(1))]}
                            + {r_prod[63], (r_prod >>> FRAC_BITS)});
                    end
                    r_step <= r_step + CW'(1);
                    if (r_step == CW'(3)) begin
                        r_state <= S_WB;
                    end
                end
                S_WB: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out.mag_out_x        <= r_res[0];
                        r_out.mag_out_y        <= r_res[1];
                        r_out.mag_out_z        <= r_res[2];
                        r_out.scale_valid      <= r_scale_ok;
                        r_out.electrode_inited <= r_inited;
                        r_out_valid            <= 1'b1;
                        r_state                <= S_IDLE;
                    end else if (o_out_valid && i_out_ready) begin
                        r_out_valid <= 1'b0;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
endmodule

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// Electrode to magnetic position mapper testbench
// Drives init, reference, convert and clear beats through the valid/ready
// input channel and compares every output beat against a behavioral model
// of the per-electrode position store and the shared axis scale.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import emp_pkg::*;

    localparam int NE = EMP_NUM_ELECTRODES;
    localparam int FB = EMP_FRAC_BITS;
    localparam longint CYCLE_LIMIT = 2000000;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_ready;
    t_in_item   i_in_data = '0;
    logic       o_out_valid;
    logic       i_out_ready = 1'b0;
    t_out_item  o_out_data;
    logic       i_cfg_we = 1'b0;
    logic       i_cfg_index = 1'b0;
    logic [5:0] i_cfg_wdata = '0;

    electrode_to_magnetic_position_mapper u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_data(o_out_data),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_wdata(i_cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    // Model state
    longint    pos_elec [NE][3];
    longint    pos_mag [NE][3];
    bit        inited [NE];
    longint    scale_vec [3];
    bit        scale_good;
    bit [5:0]  ref_idx;
    bit        auto_upd;

    t_out_item expected_beats [$];
    int        error_count = 0;
    int        beats_checked = 0;
    longint    cycle_count = 0;
    int        ref_beats = 0;
    int        valid_refs = 0;

    function automatic longint sat32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint unsigned root_floor(longint unsigned n);
        longint unsigned r = 0, b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic t_out_item predict_position(t_in_item it);
        t_out_item o;
        longint e[3], m[3], pe[3], pm[3], de[3], dm[3], res[3];
        longint unsigned se, sm, ne, nm, k, thr;
        int idx;
        idx = int'(it.electrode);
        e[0] = it.elec_x; e[1] = it.elec_y; e[2] = it.elec_z;
        m[0] = it.mag_in_x; m[1] = it.mag_in_y; m[2] = it.mag_in_z;
        res = '{0, 0, 0};
        se = 0;
        sm = 0;
        case (it.operation)
            OP_INIT: begin
                for (int a = 0; a < 3; a++) begin
                    pos_elec[idx][a] = e[a];
                    pos_mag[idx][a] = m[a];
                end
                inited[idx] = 1'b1;
            end
            OP_REF: begin
                for (int a = 0; a < 3; a++) begin
                    de[a] = sat32(e[a] - pos_elec[ref_idx][a]);
                    dm[a] = sat32(m[a] - pos_mag[ref_idx][a]);
                    se += longint'(de[a] * de[a]);
                    sm += longint'(dm[a] * dm[a]);
                end
                thr = (64'd1 << (2 * FB)) / 100;
                scale_good = se > thr;
                ref_beats++;
                if (scale_good) begin
                    valid_refs++;
                    ne = root_floor(se);
                    nm = root_floor(sm);
                    if (ne == 0) ne = 1;
                    k = (nm << FB) / ne;
                    if (k > 64'd2147483647) k = 64'd2147483647;
                    for (int a = 0; a < 3; a++)
                        scale_vec[a] = ((de[a] > 0 && dm[a] > 0) || (de[a] < 0 && dm[a] < 0))
                            ? longint'(k) : -longint'(k);
                end
            end
            OP_CONVERT: begin
                for (int a = 0; a < 3; a++) begin
                    de[a] = sat32(e[a] - pos_elec[idx][a]);
                    // Arithmetic shift floors toward minus infinity.
                    res[a] = sat32(pos_mag[idx][a] + ((de[a] * scale_vec[a]) >>> FB));
                end
                if (scale_good && auto_upd) begin
                    for (int a = 0; a < 3; a++) begin
                        pos_elec[idx][a] = e[a];
                        pos_mag[idx][a] = res[a];
                    end
                end
            end
            OP_CLEAR_ONE: inited[idx] = 1'b0;
            OP_CLEAR_ALL: for (int i = 0; i < NE; i++) inited[i] = 1'b0;
            default: ;
        endcase
        o.mag_out_x = res[0][31:0];
        o.mag_out_y = res[1][31:0];
        o.mag_out_z = res[2][31:0];
        o.scale_valid = scale_good;
        o.electrode_inited = inited[idx];
        return o;
    endfunction

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Output side: random stalls and the result checker.
    initial begin
        t_out_item exp_beat;
        int stall;
        @(posedge i_clk iff i_rst_n);
        forever begin
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
            if (stall != 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk iff o_out_valid);
            if (expected_beats.size() == 0) begin
                $error("Output beat with no expectation waiting");
                error_count++;
            end else begin
                exp_beat = expected_beats.pop_front();
                beats_checked++;
                if (o_out_data.mag_out_x !== exp_beat.mag_out_x) begin
                    $error("mag_out_x exp %h got %h", exp_beat.mag_out_x, o_out_data.mag_out_x);
                    error_count++;
                end
                if (o_out_data.mag_out_y !== exp_beat.mag_out_y) begin
                    $error("mag_out_y exp %h got %h", exp_beat.mag_out_y, o_out_data.mag_out_y);
                    error_count++;
                end
                if (o_out_data.mag_out_z !== exp_beat.mag_out_z) begin
                    $error("mag_out_z exp %h got %h", exp_beat.mag_out_z, o_out_data.mag_out_z);
                    error_count++;
                end
                if (o_out_data.scale_valid !== exp_beat.scale_valid) begin
                    $error("scale_valid exp %b got %b", exp_beat.scale_valid,
                           o_out_data.scale_valid);
                    error_count++;
                end
                if (o_out_data.electrode_inited !== exp_beat.electrode_inited) begin
                    $error("electrode_inited exp %b got %b", exp_beat.electrode_inited,
                           o_out_data.electrode_inited);
                    error_count++;
                end
            end
        end
    end

    task automatic send_beat(t_in_item it, bit no_gap = 0);
        int gap;
        gap = (no_gap || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= it;
        @(posedge i_clk iff o_in_ready);
        expected_beats.push_back(predict_position(it));
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (expected_beats.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic write_reg(logic index, logic [5:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_index <= index;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        if (index == REG_REF_ELECTRODE) ref_idx = value;
        else auto_upd = value[0];
    endtask

    function automatic logic [31:0] pick_coord();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom;
            default: return $urandom_range(0, 32'h000A_0000) - 32'h0005_0000;
        endcase
    endfunction

    function automatic t_in_item make_beat(logic [2:0] op, logic [5:0] idx);
        t_in_item it;
        it.operation = op;
        it.electrode = idx;
        it.elec_x = pick_coord(); it.elec_y = pick_coord(); it.elec_z = pick_coord();
        it.mag_in_x = pick_coord(); it.mag_in_y = pick_coord(); it.mag_in_z = pick_coord();
        return it;
    endfunction

    task automatic test_directed();
        t_in_item it;
        // Convert before any reference uses the zero scale.
        send_beat(make_beat(OP_CONVERT, 6'd5));
        it = '0;
        it.operation = OP_INIT;
        send_beat(it);
        // Reference displacement below the threshold leaves the scale invalid.
        it.operation = OP_REF;
        it.elec_x = 32'sd6553;
        it.mag_in_x = 32'sd100000;
        send_beat(it);
        it.elec_x = 32'sd6554;
        it.elec_y = -32'sd300000;
        it.mag_in_y = 32'sd300000;
        send_beat(it);
        // Extremes saturate the scale.
        it.elec_x = 32'sd1; it.elec_y = 32'sd0; it.elec_z = 32'sd7000;
        it.mag_in_x = 32'sh7FFF_FFFF; it.mag_in_y = 32'sh8000_0000;
        it.mag_in_z = 32'sh7FFF_FFFF;
        send_beat(it);
        it.operation = OP_CONVERT;
        it.electrode = 6'd0;
        it.elec_x = 32'sh7FFF_FFFF; it.elec_y = 32'sh8000_0000; it.elec_z = 32'sh8000_0000;
        send_beat(it);
        it.electrode = 6'd63;
        send_beat(it);
        send_beat(make_beat(OP_INIT, 6'd63));
        send_beat(make_beat(OP_INIT, 6'd20));
        send_beat(make_beat(OP_CLEAR_ONE, 6'd63));
        send_beat(make_beat(OP_CONVERT, 6'd20));
        send_beat(make_beat(OP_CLEAR_ALL, 6'd20));
        for (int op = 5; op < 8; op++) send_beat(make_beat(op[2:0], 6'd20));
        wait_drained();
    endtask

    task automatic test_random(int count, bit pause_once);
        t_in_item it;
        logic [5:0] hot;
        int r;
        for (int n = 0; n < count; n++) begin
            hot = 6'($urandom_range(0, 7));
            r = $urandom_range(0, 99);
            if (r < 15) begin
                it = make_beat(OP_INIT, hot);
            end else if (r < 35) begin
                // Small moves near the reference's stored position reach the threshold edge.
                it = make_beat(OP_REF, hot);
                if ($urandom_range(0, 1)) begin
                    it.elec_x = 32'(pos_elec[ref_idx][0] + $urandom_range(0, 16000) - 8000);
                    it.elec_y = 32'(pos_elec[ref_idx][1] + $urandom_range(0, 16000) - 8000);
                    it.elec_z = 32'(pos_elec[ref_idx][2]);
                end
            end else if (r < 80) begin
                it = make_beat(OP_CONVERT, ($urandom_range(0, 4) == 0) ? 6'($urandom) : hot);
            end else if (r < 90) begin
                it = make_beat(OP_CLEAR_ONE, hot);
            end else if (r < 94) begin
                it = make_beat(OP_CLEAR_ALL, 6'($urandom));
            end else begin
                it = make_beat(3'($urandom_range(5, 7)), 6'($urandom));
            end
            if (pause_once && n == count / 2) begin
                i_in_valid <= 1'b0;
                while (expected_beats.size() != 0) @(posedge i_clk);
            end
            send_beat(it, n % 40 < 8);
        end
        wait_drained();
    endtask

    task automatic test_config_sweep();
        write_reg(REG_REF_ELECTRODE, 6'd63);
        write_reg(REG_AUTO_UPDATE, 6'd0);
        test_random(180, 1'b0);
        write_reg(REG_REF_ELECTRODE, 6'd3);
        write_reg(REG_AUTO_UPDATE, 6'd1);
        test_random(180, 1'b0);
        write_reg(REG_REF_ELECTRODE, 6'd0);
        test_random(180, 1'b0);
    endtask

    initial begin
        for (int i = 0; i < NE; i++) begin
            inited[i] = 1'b0;
            for (int a = 0; a < 3; a++) begin
                pos_elec[i][a] = 0;
                pos_mag[i][a] = 0;
            end
        end
        scale_vec = '{0, 0, 0};
        scale_good = 1'b0;
        ref_idx = '0;
        auto_upd = 1'b1;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(200, 1'b1);
        test_config_sweep();
        $display("Checked %0d beats: %0d reference beats, %0d set a valid scale.",
                 beats_checked, ref_beats, valid_refs);
        $display("Both register settings and their extremes were exercised.");
        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
